// ----- sv/dbm_pkg.sv -----
// Package for the duplicate block matcher: widths, types and mask helpers.
// Used by dbm_front, dbm_back and duplicate_block_matcher_core.
`timescale 1ns / 1ps
package dbm_pkg;
	localparam int MaxBlocks = 1024;
	localparam int IdxW = 10;
	localparam int CntW = 11;
	localparam int QDepth = 2;

	typedef struct packed {
		logic        first_block;
		logic        last_block;
		logic [63:0] roll_hash;
		logic [63:0] sum_word0;
		logic [63:0] sum_word1;
		logic [63:0] sum_word2;
		logic [63:0] sum_word3;
		logic [63:0] hmask;
		logic [63:0] smask0;
		logic [63:0] smask1;
		logic [63:0] smask2;
		logic [63:0] smask3;
	} job_t;

	typedef struct packed {
		logic           found;
		logic [IdxW-1:0] cur_index;
		logic [IdxW-1:0] same_index;
		logic [IdxW-1:0] match_total;
		logic           store_full;
		logic           is_last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_WAIT, ST_CMP, ST_DONE
	} bstate_t;

	localparam logic CFG_HASH = 1'b0;
	localparam logic CFG_SUM  = 1'b1;

	function automatic logic [63:0] byte_mask(input logic [5:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++)
			if (6'(i) < n) m[i*8 +: 8] = 8'hff;
		return m;
	endfunction
endpackage

// ----- sv/dbm_front.sv -----
// Front part: accepts items, clamps the registers into masks, queues jobs.
// Depends on dbm_pkg.
`timescale 1ns / 1ps
module dbm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [5:0]       cfg_data,
	input  logic             push,
	output logic             full,
	input  logic             first_block,
	input  logic             last_block,
	input  logic [63:0]      roll_hash,
	input  logic [63:0]      sum_word0,
	input  logic [63:0]      sum_word1,
	input  logic [63:0]      sum_word2,
	input  logic [63:0]      sum_word3,
	output logic             job_valid,
	input  logic             job_take,
	output dbm_pkg::job_t    job
);
	logic [3:0] hash_bytes_q;
	logic [5:0] checksum_bytes_q;
	logic [5:0] hb, cb;
	dbm_pkg::job_t q_q [dbm_pkg::QDepth];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	dbm_pkg::job_t nj;
	logic acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_bytes_q <= 4'd8;
			checksum_bytes_q <= 6'd16;
		end else if (cfg_we) begin
			if (cfg_index == dbm_pkg::CFG_HASH) hash_bytes_q <= cfg_data[3:0];
			else checksum_bytes_q <= cfg_data;
		end
	end

	always_comb begin
		hb = {2'b0, hash_bytes_q};
		if (hb == 6'd0) hb = 6'd1;
		if (hb > 6'd8) hb = 6'd8;
		cb = checksum_bytes_q;
		if (cb == 6'd0) cb = 6'd1;
		if (cb > 6'd32) cb = 6'd32;
		nj.first_block = first_block;
		nj.last_block = last_block;
		nj.roll_hash = roll_hash;
		nj.sum_word0 = sum_word0;
		nj.sum_word1 = sum_word1;
		nj.sum_word2 = sum_word2;
		nj.sum_word3 = sum_word3;
		nj.hmask = dbm_pkg::byte_mask(hb);
		nj.smask0 = dbm_pkg::byte_mask(cb);
		nj.smask1 = (cb > 6'd8) ? dbm_pkg::byte_mask(cb - 6'd8) : '0;
		nj.smask2 = (cb > 6'd16) ? dbm_pkg::byte_mask(cb - 6'd16) : '0;
		nj.smask3 = (cb > 6'd24) ? dbm_pkg::byte_mask(cb - 6'd24) : '0;
	end

	assign full = (cnt_q == 2'd2);
	assign acc = push && !full;
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc) q_q[wr_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) wr_q <= ~wr_q;
			if (job_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(job_take);
		end
	end
endmodule

// ----- sv/dbm_back.sv -----
// Back part: scans the stored blocks newest first and builds the result.
// Depends on dbm_pkg.
`timescale 1ns / 1ps
module dbm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_take,
	input  dbm_pkg::job_t  job,
	output logic           empty,
	input  logic           pop,
	output dbm_pkg::res_t  res
);
	logic [63:0] hash_mem [dbm_pkg::MaxBlocks];
	logic [63:0] s0_mem [dbm_pkg::MaxBlocks];
	logic [63:0] s1_mem [dbm_pkg::MaxBlocks];
	logic [63:0] s2_mem [dbm_pkg::MaxBlocks];
	logic [63:0] s3_mem [dbm_pkg::MaxBlocks];
	logic [63:0] rh_q, r0_q, r1_q, r2_q, r3_q;

	dbm_pkg::bstate_t state_q, state_d;
	dbm_pkg::job_t job_q;
	logic [dbm_pkg::CntW-1:0] stored_q, k_q;
	logic [dbm_pkg::IdxW-1:0] match_q, same_q;
	logic found_q, ovf_q;
	logic [dbm_pkg::CntW-1:0] sc;
	logic [dbm_pkg::IdxW-1:0] ridx, mc;
	logic eq, wr, rd, emit;
	dbm_pkg::res_t out_q;
	logic out_v_q;

	assign sc = job_q.first_block ? '0 : stored_q;
	assign ridx = dbm_pkg::IdxW'(k_q - 1'b1);
	assign mc = job_q.first_block ? '0 : match_q;
	assign eq = (((rh_q ^ job_q.roll_hash) & job_q.hmask) == '0)
		&& (((r0_q ^ job_q.sum_word0) & job_q.smask0) == '0)
		&& (((r1_q ^ job_q.sum_word1) & job_q.smask1) == '0)
		&& (((r2_q ^ job_q.sum_word2) & job_q.smask2) == '0)
		&& (((r3_q ^ job_q.sum_word3) & job_q.smask3) == '0);

	always_comb begin
		state_d = state_q;
		job_take = 1'b0;
		rd = 1'b0;
		wr = 1'b0;
		emit = 1'b0;
		case (state_q)
			dbm_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					state_d = dbm_pkg::ST_SCAN;
				end
			end
			dbm_pkg::ST_SCAN: begin
				if (k_q == '0) state_d = dbm_pkg::ST_DONE;
				else begin
					rd = 1'b1;
					state_d = dbm_pkg::ST_WAIT;
				end
			end
			dbm_pkg::ST_WAIT: state_d = dbm_pkg::ST_CMP;
			dbm_pkg::ST_CMP: begin
				if (eq) state_d = dbm_pkg::ST_DONE;
				else state_d = dbm_pkg::ST_SCAN;
			end
			dbm_pkg::ST_DONE: begin
				if (!out_v_q || pop) begin
					emit = 1'b1;
					wr = (sc < dbm_pkg::CntW'(dbm_pkg::MaxBlocks));
					state_d = dbm_pkg::ST_IDLE;
				end
			end
			default: state_d = dbm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			rh_q <= hash_mem[ridx];
			r0_q <= s0_mem[ridx];
			r1_q <= s1_mem[ridx];
			r2_q <= s2_mem[ridx];
			r3_q <= s3_mem[ridx];
		end
		if (wr) begin
			hash_mem[sc[dbm_pkg::IdxW-1:0]] <= job_q.roll_hash;
			s0_mem[sc[dbm_pkg::IdxW-1:0]] <= job_q.sum_word0;
			s1_mem[sc[dbm_pkg::IdxW-1:0]] <= job_q.sum_word1;
			s2_mem[sc[dbm_pkg::IdxW-1:0]] <= job_q.sum_word2;
			s3_mem[sc[dbm_pkg::IdxW-1:0]] <= job_q.sum_word3;
		end
		if (job_take) job_q <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbm_pkg::ST_IDLE;
			stored_q <= '0;
			match_q <= '0;
			ovf_q <= 1'b0;
			k_q <= '0;
			found_q <= 1'b0;
			same_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
		end else begin
			state_q <= state_d;
			if (emit) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
			case (state_q)
				dbm_pkg::ST_IDLE: begin
					found_q <= 1'b0;
					same_q <= '0;
					if (job_take)
						k_q <= job.first_block ? '0 : stored_q;
				end
				dbm_pkg::ST_SCAN: if (k_q != '0) k_q <= k_q - 1'b1;
				dbm_pkg::ST_CMP: begin
					if (eq) begin
						found_q <= 1'b1;
						same_q <= dbm_pkg::IdxW'(k_q);
					end
				end
				dbm_pkg::ST_DONE: begin
					if (emit) begin
						out_q.found <= found_q;
						out_q.same_index <= same_q;
						out_q.is_last <= job_q.last_block;
						out_q.match_total <= (found_q && mc != '1) ? mc + 1'b1 : mc;
						match_q <= (found_q && mc != '1) ? mc + 1'b1 : mc;
						if (wr) begin
							out_q.cur_index <= sc[dbm_pkg::IdxW-1:0];
							out_q.store_full <= 1'b0;
							stored_q <= sc + 1'b1;
							ovf_q <= job_q.first_block ? 1'b0 : ovf_q;
						end else begin
							out_q.cur_index <= dbm_pkg::IdxW'(dbm_pkg::MaxBlocks - 1);
							out_q.store_full <= 1'b1;
							stored_q <= sc;
							ovf_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign empty = !out_v_q;
	assign res = out_q;
endmodule

// ----- sv/duplicate_block_matcher_core.sv -----
// Top level of the duplicate block matcher: front queue plus scanning back end.
// Depends on dbm_pkg, dbm_front and dbm_back.
`timescale 1ns / 1ps
// Each block is compared against the stored blocks of its set from newest to
// oldest, one stored entry at a time through the SCAN, WAIT and CMP states
// (memory read, register, compare); the number of blocks stored is at most
// 1024, and the scan stops at the first match. A two-entry input queue
// lets new items be pushed while a scan runs, and one result register holds
// the finished result until it is popped.
module duplicate_block_matcher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        first_block,
	input  logic        last_block,
	input  logic [63:0] roll_hash,
	input  logic [63:0] sum_word0,
	input  logic [63:0] sum_word1,
	input  logic [63:0] sum_word2,
	input  logic [63:0] sum_word3,
	output logic        empty,
	input  logic        pop,
	output logic        found,
	output logic [9:0]  cur_index,
	output logic [9:0]  same_index,
	output logic [9:0]  match_total,
	output logic        store_full,
	output logic        is_last
);
	logic job_valid, job_take;
	dbm_pkg::job_t job;
	dbm_pkg::res_t res;

	dbm_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .push, .full,
		.first_block, .last_block, .roll_hash, .sum_word0, .sum_word1,
		.sum_word2, .sum_word3, .job_valid, .job_take, .job
	);

	dbm_back u_back (
		.clk, .arst_n, .job_valid, .job_take, .job, .empty, .pop, .res
	);

	assign found = res.found;
	assign cur_index = res.cur_index;
	assign same_index = res.same_index;
	assign match_total = res.match_total;
	assign store_full = res.store_full;
	assign is_last = res.is_last;

`ifndef SYNTH
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid) else $error("take from empty queue");
	a_found_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && found && !store_full) |-> (same_index < cur_index))
		else $error("match not earlier");
	a_nofound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !found) |-> (same_index == 10'd0)) else $error("index without match");
`endif
endmodule

// ----- verif/tb.sv -----
// Testbench for duplicate_block_matcher_core: directed table, store-fill run and
// random sets with a built-in match predictor. Depends on dbm_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
	localparam int WdogLimit = 40000;

	typedef struct packed {
		logic        first;
		logic        last;
		logic [63:0] hash;
		logic [63:0] s0;
		logic [63:0] s1;
		logic [63:0] s2;
		logic [63:0] s3;
	} blk_t;

	typedef struct packed {
		logic chk;
		blk_t blk;
		dbm_pkg::res_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [5:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic first_block = 1'b0;
	logic last_block = 1'b0;
	logic [63:0] roll_hash = '0;
	logic [63:0] sum_word0 = '0;
	logic [63:0] sum_word1 = '0;
	logic [63:0] sum_word2 = '0;
	logic [63:0] sum_word3 = '0;
	logic empty;
	logic pop = 1'b0;
	logic found;
	logic [9:0] cur_index;
	logic [9:0] same_index;
	logic [9:0] match_total;
	logic store_full;
	logic is_last;

	duplicate_block_matcher_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [63:0] hash_mem [dbm_pkg::MaxBlocks];
	logic [63:0] sum_mem [4][dbm_pkg::MaxBlocks];
	int unsigned blocks_held;
	int unsigned dup_count;
	logic [3:0] hash_len = 4'd8;
	logic [5:0] sum_len = 6'd16;

	dbm_pkg::res_t expected_q [$];
	dbm_pkg::res_t pinned_q [$];
	logic pinned_on [$];
	int fail_cnt = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit hold_start = 1'b0;
	logic [63:0] pool [8][5];

	function automatic logic [63:0] low_bytes(input int unsigned n);
		if (n >= 8) return '1;
		if (n == 0) return '0;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic dbm_pkg::res_t match_block(input blk_t b);
		dbm_pkg::res_t r;
		int unsigned hb, cb, k;
		logic [63:0] hm;
		logic [63:0] sm [4];
		logic [63:0] sv [4];
		logic eq;
		sv[0] = b.s0;
		sv[1] = b.s1;
		sv[2] = b.s2;
		sv[3] = b.s3;
		if (b.first) begin
			blocks_held = 0;
			dup_count = 0;
		end
		hb = hash_len;
		if (hb < 1) hb = 1;
		if (hb > 8) hb = 8;
		cb = sum_len;
		if (cb < 1) cb = 1;
		if (cb > 32) cb = 32;
		hm = low_bytes(hb);
		for (int w = 0; w < 4; w++)
			sm[w] = (cb > 8 * w) ? low_bytes(cb - 8 * w) : '0;
		r = '0;
		for (k = blocks_held; k > 0; k--) begin
			eq = (((hash_mem[k-1] ^ b.hash) & hm) == 0);
			for (int w = 0; w < 4; w++)
				if (((sum_mem[w][k-1] ^ sv[w]) & sm[w]) != 0) eq = 1'b0;
			if (eq) begin
				r.found = 1'b1;
				r.same_index = 10'(k - 1);
				break;
			end
		end
		if (blocks_held >= dbm_pkg::MaxBlocks) begin
			r.store_full = 1'b1;
			r.cur_index = 10'(dbm_pkg::MaxBlocks - 1);
		end else begin
			r.cur_index = 10'(blocks_held);
			hash_mem[blocks_held] = b.hash;
			for (int w = 0; w < 4; w++) sum_mem[w][blocks_held] = sv[w];
			blocks_held++;
		end
		if (r.found && dup_count < 1023) dup_count++;
		r.match_total = 10'(dup_count);
		r.is_last = b.last;
		return r;
	endfunction

	// check accepted requests and results
	always @(posedge clk) begin
		dbm_pkg::res_t e;
		dbm_pkg::res_t p;
		logic pin;
		logic moved;
		if (arst_n) begin
			moved = (push && !full) || (pop && !empty);
			if (moved) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (cfg_we) begin
				if (cfg_index == dbm_pkg::CFG_HASH) hash_len = cfg_data[3:0];
				else sum_len = cfg_data;
			end
			if (push && !full) begin
				expected_q.push_back(match_block({first_block, last_block, roll_hash,
					sum_word0, sum_word1, sum_word2, sum_word3}));
			end
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("result with no request waiting");
					fail_cnt++;
				end else begin
					e = expected_q.pop_front();
					pin = pinned_on.pop_front();
					p = pinned_q.pop_front();
					if (pin && p != e) begin
						$error("table row disagrees with predictor: %h vs %h", p, e);
						fail_cnt++;
					end
					if (found !== e.found) begin
						$error("found exp %0d got %0d", e.found, found);
						fail_cnt++;
					end
					if (cur_index !== e.cur_index) begin
						$error("cur_index exp %0d got %0d", e.cur_index, cur_index);
						fail_cnt++;
					end
					if (same_index !== e.same_index) begin
						$error("same_index exp %0d got %0d", e.same_index, same_index);
						fail_cnt++;
					end
					if (match_total !== e.match_total) begin
						$error("match_total exp %0d got %0d", e.match_total, match_total);
						fail_cnt++;
					end
					if (store_full !== e.store_full) begin
						$error("store_full exp %0d got %0d", e.store_full, store_full);
						fail_cnt++;
					end
					if (is_last !== e.is_last) begin
						$error("is_last exp %0d got %0d", e.is_last, is_last);
						fail_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WdogLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	always @(negedge clk) begin
		int gap;
		int r;
		if (hold_start) begin
			hold_start = 1'b0;
			gap = 400;
		end
		if (!arst_n) begin
			pop <= 1'b0;
			gap = 0;
		end else if (gap > 0) begin
			pop <= 1'b0;
			gap--;
		end else begin
			pop <= 1'b1;
			r = $urandom_range(0, 99);
			if (calm || r < 60) gap = 0;
			else if (r < 95) gap = $urandom_range(1, 3);
			else gap = $urandom_range(20, 60);
		end
	end

	task automatic sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return;
		push <= 1'b0;
		if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clk);
		else repeat ($urandom_range(20, 60)) @(negedge clk);
	endtask

	task automatic send_block(input blk_t b, input logic pin, input dbm_pkg::res_t p);
		pinned_on.push_back(pin);
		pinned_q.push_back(p);
		push <= 1'b1;
		first_block <= b.first;
		last_block <= b.last;
		roll_hash <= b.hash;
		sum_word0 <= b.s0;
		sum_word1 <= b.s1;
		sum_word2 <= b.s2;
		sum_word3 <= b.s3;
		while (full) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [5:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic blk_t random_block();
		blk_t b;
		int p;
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			b = {2'b00, rand64(), rand64(), rand64(), rand64(), rand64()};
		end else begin
			p = $urandom_range(0, 7);
			b = {2'b00, pool[p][0], pool[p][1], pool[p][2], pool[p][3], pool[p][4]};
			if (r < 60) begin
				b.hash = b.hash ^ (rand64() & ~low_bytes($urandom_range(1, 8)));
				b.s2 = b.s2 ^ (rand64() & ~low_bytes($urandom_range(0, 8)));
				b.s3 = rand64();
			end else if (r < 75) begin
				b[$urandom_range(0, 319)] ^= 1'b1;
			end
		end
		b.first = ($urandom_range(0, 15) == 0);
		b.last = ($urandom_range(0, 7) == 0);
		return b;
	endfunction

	row_t plan [12];
	logic [5:0] hash_set [6] = '{6'd1, 6'd0, 6'd15, 6'd8, 6'd3, 6'd5};
	logic [5:0] sum_set [6] = '{6'd1, 6'd0, 6'd63, 6'd32, 6'd20, 6'd9};

	initial begin
		blk_t b;
		plan[0] = '{1'b1, {2'b10, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0},
			dbm_pkg::res_t'{1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0}};
		plan[1] = '{1'b1, {2'b01, {5{64'hffff_ffff_ffff_ffff}}},
			dbm_pkg::res_t'{1'b0, 10'd1, 10'd0, 10'd0, 1'b0, 1'b1}};
		plan[2] = '{1'b1, {2'b00, 64'h0, 64'h0, 64'h0, {2{64'hffff_ffff_ffff_ffff}}},
			dbm_pkg::res_t'{1'b1, 10'd2, 10'd0, 10'd1, 1'b0, 1'b0}};
		plan[3] = '{1'b1, {2'b00, 64'h00ff_ffff_ffff_ffff, {4{64'hffff_ffff_ffff_ffff}}},
			dbm_pkg::res_t'{1'b0, 10'd3, 10'd0, 10'd1, 1'b0, 1'b0}};
		plan[4] = '{1'b1, {2'b00, {5{64'hffff_ffff_ffff_ffff}}},
			dbm_pkg::res_t'{1'b1, 10'd4, 10'd1, 10'd2, 1'b0, 1'b0}};
		plan[5] = '{1'b0, {2'b00, 64'h8000_0000_0000_0000, 64'h1, 64'h0, 64'h0, 64'h0},
			'0};
		plan[6] = '{1'b0, {2'b00, 64'h0, 64'h0, 64'h8000_0000_0000_0000, 64'h0, 64'h5},
			'0};
		plan[7] = '{1'b0, {2'b01, 64'h0, 64'h0, 64'h0, 64'h1, 64'h0}, '0};
		plan[8] = '{1'b1, {2'b10, {5{64'hffff_ffff_ffff_ffff}}},
			dbm_pkg::res_t'{1'b0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0}};
		plan[9] = '{1'b0, {2'b00, 64'h5555_aaaa_5555_aaaa, 64'h1234, 64'h0, 64'h0, 64'h0},
			'0};
		plan[10] = '{1'b0, {2'b00, 64'h5555_aaaa_5555_aaaa, 64'h1234, 64'h0, 64'h0, 64'h0},
			'0};
		plan[11] = '{1'b0, {2'b01, {5{64'hffff_ffff_ffff_ffff}}}, '0};
		for (int i = 0; i < 8; i++)
			for (int j = 0; j < 5; j++) pool[i][j] = rand64();

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			sender_gap();
			send_block(plan[i].blk, plan[i].chk, plan[i].res);
		end
		drain();

		// identical blocks match at once, so the store fills fast; run past capacity
		calm = 1'b1;
		b = '0;
		b.hash = 64'hdead_beef_0123_4567;
		b.s0 = 64'h0f0f_0f0f_f0f0_f0f0;
		b.s1 = 64'h1;
		for (int i = 0; i < dbm_pkg::MaxBlocks + 3; i++) begin
			b.first = (i == 0);
			b.last = (i == dbm_pkg::MaxBlocks + 2);
			b.s3 = rand64();
			send_block(b, 1'b0, '0);
		end
		b.first = 1'b1;
		b.last = 1'b0;
		send_block(b, 1'b0, '0);
		calm = 1'b0;
		drain();

		foreach (hash_set[ph]) begin
			write_reg(dbm_pkg::CFG_HASH, hash_set[ph]);
			write_reg(dbm_pkg::CFG_SUM, sum_set[ph]);
			if (ph == 1) hold_start = 1'b1;
			calm = (ph == 4);
			for (int n = 0; n < 65; n++) begin
				b = random_block();
				if (n == 0) b.first = 1'b1;
				if (!(ph == 1 && n < 20)) sender_gap();
				send_block(b, 1'b0, '0);
			end
			drain();
		end

		if (fail_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/dbm_pkg.sv
sv/dbm_front.sv
sv/dbm_back.sv
sv/duplicate_block_matcher_core.sv
verif/tb.sv
